>>> hdl/plcm_pkg.sv
// Shared types and constants for the packet loss congestion meter.
package plcm_pkg;

  localparam int unsigned SeqW   = 32;
  localparam int unsigned TimeW  = 31;
  localparam int unsigned RttW   = 16;
  localparam int unsigned PctW   = 7;
  localparam int unsigned DivW   = 16;
  localparam int unsigned ProdW  = RttW + PctW;
  localparam int unsigned InTdW  = 112;
  localparam int unsigned OutTdW = 40;

  localparam logic [PctW-1:0] LoadPctRst = 7'd5;
  localparam logic [PctW-1:0] CongPctRst = 7'd10;
  localparam logic [RttW-1:0] MinPktNum  = 16'd200;

  // Register indexes of the configuration port.
  localparam logic CfgLoadPct = 1'b0;
  localparam logic CfgCongPct = 1'b1;

  // Load levels.
  localparam logic [1:0] LvlUnloaded  = 2'd0;
  localparam logic [1:0] LvlLoaded    = 2'd1;
  localparam logic [1:0] LvlCongested = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_UPDATE,
    OP_DEVIATE,
    OP_SEQ_SCAN,
    OP_APPLY_A,
    OP_APPLY_B,
    OP_AGE_SCAN,
    OP_DIV_PPS,
    OP_PROD,
    OP_DIV_MIN,
    OP_MUL,
    OP_LEVEL
  } op_e;

  typedef struct packed {
    logic scan_done;
    logic div_done;
    logic pps_low;
  } plcm_status_t;

endpackage

>>> hdl/plcm_ctrl.sv
// Sequencing state machine for the congestion meter.
module plcm_ctrl
  import plcm_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  plcm_status_t status_i,
  output op_e          op_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_UPD, S_DEV, S_SSCAN, S_SWAIT, S_APA, S_APB, S_ASCAN, S_AWAIT,
    S_DSTART, S_DWAIT1, S_PROD, S_CHK, S_D2START, S_DWAIT2, S_MUL, S_LVL, S_FIN
  } state_e;

  state_e st_q;
  op_e    op_q;
  logic   out_valid_q;

  assign in_ready_o  = (st_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign op_o        = op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      op_q        <= OP_NONE;
      out_valid_q <= 1'b0;
    end else begin
      op_q <= OP_NONE;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (st_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q <= OP_UPDATE;
            st_q <= S_UPD;
          end
        end
        S_UPD: begin
          op_q <= OP_DEVIATE;
          st_q <= S_DEV;
        end
        S_DEV: begin
          op_q <= OP_SEQ_SCAN;
          st_q <= S_SSCAN;
        end
        S_SSCAN: st_q <= S_SWAIT;
        S_SWAIT: begin
          if (status_i.scan_done) begin
            op_q <= OP_APPLY_A;
            st_q <= S_APA;
          end
        end
        S_APA: begin
          op_q <= OP_APPLY_B;
          st_q <= S_APB;
        end
        S_APB: begin
          op_q <= OP_AGE_SCAN;
          st_q <= S_ASCAN;
        end
        S_ASCAN: st_q <= S_AWAIT;
        S_AWAIT: begin
          if (status_i.scan_done) begin
            op_q <= OP_DIV_PPS;
            st_q <= S_DSTART;
          end
        end
        S_DSTART: st_q <= S_DWAIT1;
        S_DWAIT1: begin
          if (status_i.div_done) begin
            op_q <= OP_PROD;
            st_q <= S_PROD;
          end
        end
        S_PROD: st_q <= S_CHK;
        S_CHK: begin
          if (status_i.pps_low) begin
            op_q <= OP_DIV_MIN;
            st_q <= S_D2START;
          end else begin
            op_q <= OP_MUL;
            st_q <= S_MUL;
          end
        end
        S_D2START: st_q <= S_DWAIT2;
        S_DWAIT2: begin
          if (status_i.div_done) begin
            op_q <= OP_MUL;
            st_q <= S_MUL;
          end
        end
        S_MUL: st_q <= S_LVL;
        S_LVL: begin
          // result slot must be free before the output registers are loaded
          if (!out_valid_q || out_ready_i) begin
            op_q <= OP_LEVEL;
            st_q <= S_FIN;
          end
        end
        S_FIN: begin
          out_valid_q <= 1'b1;
          st_q        <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fin_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_FIN) |-> !out_valid_q)
    else $error("result overwritten while still pending");
  a_fin_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_FIN) |=> out_valid_q)
    else $error("result not presented after level step");
  a_valid_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(st_q == S_FIN))
    else $error("result valid raised outside final step");
`endif

endmodule

>>> hdl/plcm_dp.sv
// Datapath: estimators, hole table, divider and load decision.
module plcm_dp
  import plcm_pkg::*;
#(
  parameter int unsigned HOLE_ENTRIES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_accept_i,
  input  logic [TimeW-1:0] sender_time_ms_i,
  input  logic [TimeW-1:0] arrival_time_ms_i,
  input  logic [SeqW-1:0]  sequence_number_i,
  input  logic [RttW-1:0]  round_trip_ms_i,
  input  logic             cfg_we_i,
  input  logic             cfg_index_i,
  input  logic [PctW-1:0]  cfg_data_i,
  input  op_e              op_i,
  output plcm_status_t     status_o,
  output logic [1:0]       load_level_o,
  output logic [SeqW-1:0]  lost_count_o,
  output logic             table_overflow_o
);

  localparam int unsigned IW  = (HOLE_ENTRIES > 1) ? $clog2(HOLE_ENTRIES) : 1;
  localparam int unsigned CW  = $clog2(HOLE_ENTRIES + 1);
  localparam int unsigned DCW = $clog2(DivW);
  localparam logic [CW-1:0]  LastCnt  = CW'(HOLE_ENTRIES);
  localparam logic [DCW-1:0] LastStep = DCW'(DivW - 1);

  typedef enum logic [1:0] {CLS_PLAIN, CLS_NEW, CLS_LATE} cls_e;

  // latched item
  logic [TimeW-1:0] sender_q, now_q;
  logic [SeqW-1:0]  seq_q;
  logic [RttW-1:0]  rtt_q;

  // configuration and estimator state
  logic [PctW-1:0]  lth_q, cth_q;
  logic [31:0]      gap_q, exp_q, mean_q, dev_q;
  logic [TimeW-1:0] last_q;
  logic signed [31:0] diff_q;
  logic signed [34:0] vend_q, vstart_q;
  cls_e             cls_q;
  logic [SeqW-1:0]  newf_q;
  logic             ovf_q, split_q;

  // hole table
  logic [SeqW-1:0]  first_mem [HOLE_ENTRIES];
  logic [SeqW-1:0]  last_mem  [HOLE_ENTRIES];
  logic [TimeW-1:0] stamp_mem [HOLE_ENTRIES];
  logic [HOLE_ENTRIES-1:0] vld_q, vld_d;
  logic [SeqW-1:0]  first_rd_q, last_rd_q;
  logic [TimeW-1:0] stamp_rd_q;

  // scan
  logic          scan_act_q, pend_q, age_q;
  logic [CW-1:0] scan_cnt_q;
  logic [IW-1:0] pend_idx_q, hit_idx_q, free_idx_q;
  logic          hit_q, free_q;
  logic [SeqW-1:0] hit_first_q, hit_last_q;
  logic [SeqW-1:0] lost_q;

  // divider and decision
  logic           div_busy_q;
  logic [DCW-1:0] div_cnt_q;
  logic [32:0]    rem_q;
  logic [DivW-1:0] quo_q, pps_q;
  logic [31:0]    den_q;
  logic [ProdW-1:0] prod_q, lprod_q, cprod_q;
  logic [1:0]     level_q;
  logic [SeqW-1:0] out_lost_q;
  logic           out_ovf_q;

  // write port
  logic          we_first, we_last, we_stamp;
  logic [IW-1:0] wr_addr;
  logic [SeqW-1:0]  wd_first, wd_last;

  logic [SeqW-1:0] seq_inc, seq_dec;
  logic [PctW-1:0] cth_eff;
  assign seq_inc = seq_q + 32'd1;
  assign seq_dec = seq_q - 32'd1;
  assign cth_eff = (cth_q == '0) ? PctW'(1) : cth_q;

  // ---- gap and mean updates ----
  logic [35:0]        gap15;
  logic signed [37:0] gap_sum, gap_div;
  logic [31:0]        gap_n;
  logic signed [31:0] diff_n;
  logic signed [35:0] mean_ext, mean7, mean_n;
  assign gap15   = ({4'b0, gap_q} << 4) - {4'b0, gap_q};
  assign gap_sum = $signed({2'b0, gap15}) + $signed({7'b0, now_q})
                 - $signed({7'b0, last_q});
  assign gap_div = gap_sum >>> 4;
  assign gap_n   = (gap_q == '0) ? {1'b0, now_q}
                 : (gap_div < 38'sd1) ? 32'd1 : gap_div[31:0];
  assign diff_n  = $signed({1'b0, now_q}) - $signed({1'b0, sender_q});
  assign mean_ext = 36'(signed'(mean_q));
  assign mean7    = (mean_ext <<< 3) - mean_ext;
  assign mean_n   = (mean_q == '0) ? 36'(diff_n)
                  : ((mean7 + 36'(diff_n)) >>> 3);

  // ---- deviation ----
  logic signed [35:0] dev_diff;
  logic [35:0]        dev_abs;
  logic [36:0]        dev_sum;
  assign dev_diff = 36'(signed'(mean_q)) - 36'(diff_q);
  assign dev_abs  = dev_diff[35] ? 36'(-dev_diff) : 36'(dev_diff);
  assign dev_sum  = ({5'b0, dev_q} << 3) - {5'b0, dev_q} + {1'b0, dev_abs};

  // ---- window bounds ----
  logic signed [34:0] vend_n;
  assign vend_n = $signed({4'b0, now_q}) - $signed({2'b0, dev_q, 1'b0});

  // ---- scan compares ----
  logic        pend_vld, in_hole;
  logic [32:0] hole_size;
  logic [33:0] lost_sum;
  logic signed [34:0] stamp_s;
  assign pend_vld  = vld_q[pend_idx_q];
  assign in_hole   = (first_rd_q <= seq_q) && (seq_q <= last_rd_q);
  assign hole_size = {1'b0, last_rd_q - first_rd_q} + 33'd1;
  assign lost_sum  = {2'b0, lost_q} + {1'b0, hole_size};
  assign stamp_s   = $signed({4'b0, stamp_rd_q});

  // ---- divider step ----
  logic [32:0]     rem_sh, rem_n;
  logic            qbit;
  logic [DivW-1:0] quo_n;
  assign rem_sh = {rem_q[31:0], quo_q[DivW-1]};
  assign qbit   = (rem_sh >= {1'b0, den_q});
  assign rem_n  = qbit ? (rem_sh - {1'b0, den_q}) : rem_sh;
  assign quo_n  = {quo_q[DivW-2:0], qbit};

  // ---- level ----
  logic [38:0] lost100;
  logic [1:0]  level_n;
  assign lost100 = ({7'b0, lost_q} << 6) + ({7'b0, lost_q} << 5) + ({7'b0, lost_q} << 2);
  always_comb begin
    priority if (lost100 <= {16'b0, lprod_q}) level_n = LvlUnloaded;
    else if (lost100 <= {16'b0, cprod_q})     level_n = LvlLoaded;
    else                                      level_n = LvlCongested;
  end

  // ---- hole table updates ----
  logic ovf_set, split_set;
  always_comb begin
    vld_d     = vld_q;
    we_first  = 1'b0;
    we_last   = 1'b0;
    we_stamp  = 1'b0;
    wr_addr   = free_idx_q;
    wd_first  = seq_inc;
    wd_last   = seq_dec;
    ovf_set   = 1'b0;
    split_set = 1'b0;
    if (op_i == OP_APPLY_A) begin
      if (cls_q == CLS_NEW) begin
        if (free_q) begin
          we_first = 1'b1;
          we_last  = 1'b1;
          we_stamp = 1'b1;
          wd_first = newf_q;
          vld_d[free_idx_q] = 1'b1;
        end else begin
          ovf_set = 1'b1;
        end
      end else if (cls_q == CLS_LATE && hit_q) begin
        priority if (hit_first_q == seq_q && hit_last_q == seq_q) begin
          vld_d[hit_idx_q] = 1'b0;
        end else if (hit_first_q == seq_q) begin
          wr_addr  = hit_idx_q;
          we_first = 1'b1;
        end else if (hit_last_q == seq_q) begin
          wr_addr = hit_idx_q;
          we_last = 1'b1;
        end else if (free_q) begin
          // split: upper part moves to a fresh entry
          we_first  = 1'b1;
          we_last   = 1'b1;
          we_stamp  = 1'b1;
          wd_last   = hit_last_q;
          split_set = 1'b1;
          vld_d[free_idx_q] = 1'b1;
        end else begin
          ovf_set = 1'b1;
        end
      end
    end else if (op_i == OP_APPLY_B && split_q) begin
      wr_addr = hit_idx_q;
      we_last = 1'b1;
    end else if (pend_q && age_q && pend_vld && (stamp_s < vstart_q)) begin
      vld_d[pend_idx_q] = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_first) first_mem[wr_addr] <= wd_first;
    if (we_last)  last_mem[wr_addr]  <= wd_last;
    if (we_stamp) stamp_mem[wr_addr] <= now_q;
    first_rd_q <= first_mem[scan_cnt_q[IW-1:0]];
    last_rd_q  <= last_mem[scan_cnt_q[IW-1:0]];
    stamp_rd_q <= stamp_mem[scan_cnt_q[IW-1:0]];
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lth_q      <= LoadPctRst;
      cth_q      <= CongPctRst;
      gap_q      <= '0;
      last_q     <= '0;
      exp_q      <= '0;
      mean_q     <= '0;
      dev_q      <= '0;
      vld_q      <= '0;
      scan_act_q <= 1'b0;
      pend_q     <= 1'b0;
      scan_cnt_q <= '0;
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
    end else begin
      vld_q <= vld_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgLoadPct: lth_q <= cfg_data_i;
          CfgCongPct: cth_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (op_i == OP_UPDATE) begin
        gap_q  <= gap_n;
        last_q <= now_q;
        mean_q <= mean_n[31:0];
        if (exp_q == '0 || seq_q >= exp_q) exp_q <= seq_inc;
      end
      if (op_i == OP_DEVIATE) dev_q <= dev_sum[34:3];
      // table walk, one read issued per cycle
      if (op_i == OP_SEQ_SCAN || op_i == OP_AGE_SCAN) begin
        scan_act_q <= 1'b1;
        scan_cnt_q <= '0;
        pend_q     <= 1'b0;
      end else if (scan_act_q) begin
        if (scan_cnt_q != LastCnt) begin
          pend_q     <= 1'b1;
          scan_cnt_q <= scan_cnt_q + CW'(1);
        end else begin
          pend_q     <= 1'b0;
          scan_act_q <= 1'b0;
        end
      end
      if (op_i == OP_DIV_PPS || op_i == OP_DIV_MIN) begin
        div_busy_q <= 1'b1;
        div_cnt_q  <= '0;
      end else if (div_busy_q) begin
        div_cnt_q <= div_cnt_q + DCW'(1);
        if (div_cnt_q == LastStep) div_busy_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      sender_q <= sender_time_ms_i;
      now_q    <= arrival_time_ms_i;
      seq_q    <= sequence_number_i;
      rtt_q    <= round_trip_ms_i;
    end
    if (op_i == OP_UPDATE) begin
      diff_q  <= diff_n;
      newf_q  <= exp_q;
      ovf_q   <= 1'b0;
      split_q <= 1'b0;
      if (exp_q == '0 || seq_q == exp_q) cls_q <= CLS_PLAIN;
      else if (seq_q > exp_q)            cls_q <= CLS_NEW;
      else                               cls_q <= CLS_LATE;
    end
    if (ovf_set)   ovf_q   <= 1'b1;
    if (split_set) split_q <= 1'b1;
    if (op_i == OP_SEQ_SCAN) begin
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
      vend_q   <= vend_n;
      vstart_q <= vend_n - $signed({19'b0, rtt_q});
    end
    if (op_i == OP_AGE_SCAN) lost_q <= '0;
    if (scan_act_q) pend_idx_q <= scan_cnt_q[IW-1:0];
    if (pend_q && !age_q) begin
      if (pend_vld && !hit_q && in_hole) begin
        hit_q       <= 1'b1;
        hit_idx_q   <= pend_idx_q;
        hit_first_q <= first_rd_q;
        hit_last_q  <= last_rd_q;
      end
      if (!pend_vld && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= pend_idx_q;
      end
    end
    if (pend_q && age_q && pend_vld && !(stamp_s < vstart_q) && (stamp_s < vend_q)) begin
      lost_q <= (lost_sum[33:32] != 2'b0) ? '1 : lost_sum[31:0];
    end
    if (op_i == OP_SEQ_SCAN || op_i == OP_AGE_SCAN) age_q <= (op_i == OP_AGE_SCAN);
    // divider
    if (op_i == OP_DIV_PPS) begin
      rem_q <= '0;
      quo_q <= rtt_q;
      den_q <= gap_q;
    end else if (op_i == OP_DIV_MIN) begin
      rem_q <= '0;
      quo_q <= MinPktNum;
      den_q <= {25'b0, cth_eff};
    end else if (div_busy_q) begin
      rem_q <= rem_n;
      quo_q <= quo_n;
      if (div_cnt_q == LastStep) pps_q <= (den_q == '0) ? '0 : quo_n;
    end
    if (op_i == OP_PROD) prod_q <= pps_q * cth_eff;
    if (op_i == OP_MUL) begin
      lprod_q <= pps_q * lth_q;
      cprod_q <= pps_q * cth_eff;
    end
    if (op_i == OP_LEVEL) begin
      level_q    <= level_n;
      out_lost_q <= lost_q;
      out_ovf_q  <= ovf_q;
    end
  end

  assign status_o.scan_done = !scan_act_q && !pend_q;
  assign status_o.div_done  = !div_busy_q;
  assign status_o.pps_low   = (prod_q < ProdW'(MinPktNum));

  assign load_level_o     = level_q;
  assign lost_count_o     = out_lost_q;
  assign table_overflow_o = out_ovf_q;

`ifndef SYNTHESIS
  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(scan_act_q && div_busy_q))
    else $error("table walk and divider active together");
  a_hit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_APPLY_A && cls_q == CLS_LATE && hit_q) |-> vld_q[hit_idx_q])
    else $error("hit entry not valid at update");
  a_free_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_APPLY_A && free_q) |-> !vld_q[free_idx_q])
    else $error("free entry already in use");
`endif

endmodule

>>> hdl/packet_loss_congestion_meter.sv
// Top level of the packet loss congestion meter.
//
// Usage:
//   Slave beats carry one packet arrival (sender time, arrival time,
//   sequence number, rtt). Each accepted beat produces exactly one master
//   beat with the load level, the lost packet count and a table overflow
//   flag. Thresholds are set through the cfg write port while idle.
// Processing:
//   One packet at a time: a new slave beat is taken only once the
//   previous packet's processing is done. The two walks over the hole
//   table (one entry per cycle through its single read port) and the
//   16-step divider take most of the processing time; a second divide
//   runs when few packets fit in one rtt.
// Reset:
//   All estimators clear, all holes become invalid, thresholds return to
//   5 and 10 percent. No result is pending.
// Stall:
//   The result sits in an output register; the next packet is accepted
//   and processed while it waits, and that packet's result is held back
//   until the pending beat is taken.
module packet_loss_congestion_meter_core
  import plcm_pkg::*;
#(
  parameter int unsigned HOLE_ENTRIES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // [30:0] sender_time_ms, [61:31] arrival_time_ms,
  // [93:62] sequence_number, [109:94] round_trip_ms, [111:110] zero
  input  logic [InTdW-1:0]  s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [1:0] load_level, [33:2] lost_count, [34] table_overflow, [39:35] zero
  output logic [OutTdW-1:0] m_axis_tdata,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [PctW-1:0]   cfg_data_i
);

  op_e          op;
  plcm_status_t status;
  logic         in_accept;
  logic [1:0]   load_level;
  logic [SeqW-1:0] lost_count;
  logic         table_overflow;

  assign in_accept = s_axis_tvalid && s_axis_tready;

  plcm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .op_o        (op)
  );

  plcm_dp #(
    .HOLE_ENTRIES (HOLE_ENTRIES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_accept_i       (in_accept),
    .sender_time_ms_i  (s_axis_tdata[30:0]),
    .arrival_time_ms_i (s_axis_tdata[61:31]),
    .sequence_number_i (s_axis_tdata[93:62]),
    .round_trip_ms_i   (s_axis_tdata[109:94]),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .op_i              (op),
    .status_o          (status),
    .load_level_o      (load_level),
    .lost_count_o      (lost_count),
    .table_overflow_o  (table_overflow)
  );

  assign m_axis_tdata = {5'b0, table_overflow, lost_count, load_level};

endmodule

>>> sim/tb_packet_loss_congestion_meter_core.sv
// Testbench for the packet loss congestion meter: random and directed packets, scoreboard check.
module tb_packet_loss_congestion_meter_core;
  import plcm_pkg::*;

  localparam int unsigned Holes = 16;

  // Expected-result store plus a private copy of the meter state.
  class loss_meter_scoreboard;
    logic [PctW-1:0] load_pct, cong_pct;
    logic [31:0] gap_est, last_arr, next_seq, mean_q, dev_q;
    bit          hv[Holes];
    logic [31:0] hf[Holes], hl[Holes], hs[Holes];
    logic [OutTdW-1:0] pending[$];
    int errors;

    function new();
      load_pct = LoadPctRst;
      cong_pct = CongPctRst;
      gap_est = 0; last_arr = 0; next_seq = 0; mean_q = 0; dev_q = 0;
      foreach (hv[i]) hv[i] = 0;
      errors = 0;
    endfunction

    static function longint fdiv(longint v, longint d);
      if (v >= 0) return v / d;
      return -((-v + d - 1) / d);
    endfunction

    function int free_entry();
      for (int i = 0; i < Holes; i++) if (!hv[i]) return i;
      return -1;
    endfunction

    function void set_reg(logic idx, logic [PctW-1:0] v);
      if (idx == CfgLoadPct) load_pct = v;
      else cong_pct = v;
    endfunction

    // Note an accepted packet; push its expected result.
    function void note_packet(logic [InTdW-1:0] d);
      longint ts, now, rtt, g, diff, mean, dv, vend, vstart;
      logic [31:0] seq;
      longint unsigned lost, pps, cth, lth;
      logic [1:0] lvl;
      bit ovf;
      int h, s;
      ts = d[30:0]; now = d[61:31]; seq = d[93:62]; rtt = d[109:94];
      ovf = 0; lost = 0;
      if (gap_est != 0) begin
        g = fdiv(15 * longint'(gap_est) + now - longint'(last_arr), 16);
        gap_est = (g < 1) ? 32'd1 : g[31:0];
      end else begin
        gap_est = now[31:0];
      end
      last_arr = now[31:0];
      if (next_seq == 0) begin
        next_seq = seq + 1;
      end else if (seq == next_seq) begin
        next_seq++;
      end else if (seq > next_seq) begin
        s = free_entry();
        if (s >= 0) begin
          hv[s] = 1; hs[s] = now[31:0]; hf[s] = next_seq; hl[s] = seq - 1;
        end else begin
          ovf = 1;
        end
        next_seq = seq + 1;
      end else begin
        h = -1;
        for (int i = 0; i < Holes; i++)
          if (h < 0 && hv[i] && hf[i] <= seq && seq <= hl[i]) h = i;
        if (h >= 0) begin
          if (hf[h] == seq && hl[h] == seq) hv[h] = 0;
          else if (hf[h] == seq) hf[h]++;
          else if (hl[h] == seq) hl[h]--;
          else begin
            s = free_entry();
            if (s >= 0) begin
              hv[s] = 1; hs[s] = now[31:0]; hf[s] = seq + 1; hl[s] = hl[h];
              hl[h] = seq - 1;
            end else begin
              ovf = 1;
            end
          end
        end
      end
      diff = now - ts;
      mean = longint'(signed'(mean_q));
      if (mean == 0) mean = diff;
      else mean = fdiv(7 * mean + diff, 8);
      mean_q = mean[31:0];
      dv = (mean - diff < 0) ? diff - mean : mean - diff;
      dev_q = 32'((7 * longint'(dev_q) + dv) / 8);
      vend = now - 2 * longint'(dev_q);
      vstart = vend - rtt;
      for (int i = 0; i < Holes; i++) begin
        if (hv[i]) begin
          if (longint'(hs[i]) < vstart) hv[i] = 0;
          else if (longint'(hs[i]) < vend) begin
            lost += longint'(hl[i] - hf[i]) + 1;
            if (lost > 64'hFFFF_FFFF) lost = 64'hFFFF_FFFF;
          end
        end
      end
      cth = (cong_pct != 0) ? cong_pct : 1;
      lth = load_pct;
      pps = (gap_est != 0) ? rtt / gap_est : 0;
      if ((pps * cth) / 100 < 2) pps = MinPktNum / cth;
      if (lost <= (lth * pps) / 100) lvl = LvlUnloaded;
      else if (lost <= (cth * pps) / 100) lvl = LvlLoaded;
      else lvl = LvlCongested;
      pending.push_back({5'd0, ovf, lost[31:0], lvl});
    endfunction

    function void check_result(logic [OutTdW-1:0] got);
      logic [OutTdW-1:0] want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", got);
        return;
      end
      want = pending.pop_front();
      if (got[1:0] !== want[1:0] || got[33:2] !== want[33:2] || got[34] !== want[34]
          || got[39:35] !== want[39:35]) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: level %0d/%0d lost %0d/%0d ovf %0b/%0b (exp/got)",
                   want[1:0], got[1:0], want[33:2], got[33:2], want[34], got[34]);
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic s_axis_tvalid = 0, m_axis_tready = 0;
  logic s_axis_tready, m_axis_tvalid;
  logic [InTdW-1:0] s_axis_tdata = '0;
  logic [OutTdW-1:0] m_axis_tdata;
  logic cfg_we_i = 0, cfg_index_i = CfgLoadPct;
  logic [PctW-1:0] cfg_data_i = '0;

  loss_meter_scoreboard sb = new();
  bit drain_hold = 0;   // receiver long hold-off request
  bit stim_done = 0;

  // sender state of the synthetic flow
  logic [31:0] flow_seq;
  logic [30:0] flow_now, flow_ts;

  always #4 clk_i = ~clk_i;

  packet_loss_congestion_meter_core #(.HOLE_ENTRIES(Holes)) DUT (.*);

  function automatic int gap_len();
    if ($urandom_range(9) == 0) return $urandom_range(60, 10);
    if ($urandom_range(2) == 0) return 0;
    return $urandom_range(3);
  endfunction

  // Offer one beat; hold until accepted, then drop valid for a random gap.
  task automatic send_packet(logic [30:0] ts, logic [30:0] now, logic [31:0] seq,
                             logic [15:0] rtt);
    int n;
    s_axis_tdata  <= {2'b00, rtt, seq, now, ts};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_packet({2'b00, rtt, seq, now, ts});
    // valid stays up when the next beat follows at once
    n = gap_len();
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (2 * Holes + 60) @(posedge clk_i);
  endtask

  // Write enable is left high; the caller drops it after the last write.
  task automatic write_reg(logic idx, logic [PctW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  // Mostly a well-formed flow: in order, some jumps, some late fills, some noise.
  task automatic flow_packet();
    logic [31:0] seq;
    int k;
    k = $urandom_range(99);
    flow_now = flow_now + 31'($urandom_range(40));
    flow_ts  = flow_now - 31'($urandom_range(200));
    if (k < 55) begin
      seq = flow_seq; flow_seq++;
    end else if (k < 75) begin
      flow_seq = flow_seq + $urandom_range(20, 1); seq = flow_seq; flow_seq++;
    end else if (k < 92) begin
      seq = flow_seq - $urandom_range(25, 1);
    end else begin
      seq = $urandom();
      flow_now = 31'($urandom());
      flow_ts = 31'($urandom());
      if (seq >= flow_seq) flow_seq = seq + 1;
    end
    send_packet(flow_ts, flow_now, seq, $urandom_range(99) < 80 ? 16'($urandom_range(800))
                                                                 : 16'($urandom()));
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int n;
    @(posedge rst_ni);
    while (1) begin
      if (drain_hold) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        drain_hold = 0;
      end
      n = gap_len();
      m_axis_tready <= (n == 0);
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (n > 0) begin
        repeat (n - 1) @(posedge clk_i);
        m_axis_tready <= 1'b1;
        do begin
          @(posedge clk_i);
          if (m_axis_tvalid) sb.check_result(m_axis_tdata);
        end while (!m_axis_tvalid && !drain_hold);
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, wrap, holes, late fills, split, overflow.
    send_packet(31'h7FFF_FFFF, 31'h0, 32'hFFFF_FFFF, 16'hFFFF);   // seq wraps to 0
    send_packet(31'h0, 31'h7FFF_FFFF, 32'd10, 16'd0);
    send_packet(31'h0, 31'h0, 32'd1, 16'd100);                    // backward time
    send_packet(31'd5, 31'd10, 32'd20, 16'd500);                  // new hole
    send_packet(31'd5, 31'd12, 32'd11, 16'd500);                  // late, trim front
    send_packet(31'd5, 31'd14, 32'd13, 16'd500);                  // late, split
    send_packet(31'd5, 31'd16, 32'd14, 16'd500);                  // trim front
    send_packet(31'd5, 31'd18, 32'd19, 16'd500);                  // trim back
    send_packet(31'd5, 31'd20, 32'd30, 16'd500);
    send_packet(31'd5, 31'd22, 32'd29, 16'd500);
    send_packet(31'd5, 31'd24, 32'd28, 16'd500);
    for (int i = 0; i < 18; i++)                                 // fill table, overflow
      send_packet(31'd5, 31'(26 + i), 32'(40 + 3 * i), 16'hFFFF);
    send_packet(31'd5, 31'd50, 32'd41, 16'hFFFF);                 // trim front on full table
    wait_idle();

    flow_seq = 100; flow_now = 1000; flow_ts = 900;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(CfgLoadPct, 7'd0);   write_reg(CfgCongPct, 7'd0);   end
        1: begin write_reg(CfgLoadPct, 7'd100); write_reg(CfgCongPct, 7'd100); end
        2: begin write_reg(CfgLoadPct, 7'd127); write_reg(CfgCongPct, 7'd1);   end
        default: begin
          write_reg(CfgLoadPct, 7'($urandom_range(100)));
          write_reg(CfgCongPct, 7'($urandom_range(100, 1)));
        end
      endcase
      cfg_we_i <= 1'b0;
      if (ph == 3) drain_hold = 1;
      for (int i = 0; i < 290; i++) flow_packet();
      wait_idle();   // also the full-drain pause of the sender
    end
    // Noise with extreme bits everywhere.
    for (int i = 0; i < 30; i++)
      send_packet(31'($urandom()), 31'($urandom()), $urandom(), 16'($urandom()));
    wait_idle();
    if (sb.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end

endmodule
